>>> src/hpid_pkg.sv
// Shared types and constants for the heater PID controller.
// No dependencies; imported by the top level.
package hpid_pkg;

   localparam int HEATER_W   = 2;
   localparam int TEMP_W     = 16;
   localparam int GAIN_W     = 24;
   localparam int RISE_W     = 8;
   localparam int CTRL_W     = 14;
   localparam int POWER_W    = 11;
   localparam int INTEG_W    = 32;
   localparam int ERR_W      = TEMP_W + 1;
   localparam int DIFF_W     = ERR_W + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // product and accumulator widths (gains enter as signed with a zero msb)
   localparam int P_PROD_W = ERR_W + GAIN_W + 1;
   localparam int I_PROD_W = INTEG_W + GAIN_W + 1;
   localparam int D_PROD_W = DIFF_W + GAIN_W + 1;
   localparam int PD_SUM_W = D_PROD_W + 1;
   localparam int ACC_W    = I_PROD_W + 1;
   localparam int SCALED_W = CTRL_W + 1;

   localparam int FLOW_COUNT = 2;

   localparam logic [CTRL_W-1:0] CTRL_MAX        = 14'd10000;
   localparam logic [CTRL_W-1:0] CTRL_HIGH_LIMIT = 14'd7500;
   localparam int                CTRL_MIN        = 10;
   localparam logic signed [ACC_W-1:0] ACC_MIN   = ACC_W'(CTRL_MIN * 256);
   localparam logic signed [ERR_W-1:0] DEV_LIMIT = ERR_W'(50);

   // floor(c*100000/833333) == floor(3c/25) for c <= 10000;
   // x/25 == (x*41944) >> 20 for x < 43690
   localparam logic [15:0] POWER_RECIP = 16'd41944;
   localparam int          POWER_SHIFT = 20;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P_MAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I_MAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D_MAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P_BREW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I_BREW  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D_BREW  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_RISE     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_EFAST_CUTOFF = 3'd7;

   // register reset values
   localparam logic [GAIN_W-1:0] RST_GAIN_P_MAIN  = 24'd25600;
   localparam logic [GAIN_W-1:0] RST_GAIN_I_MAIN  = 24'd1152;
   localparam logic [GAIN_W-1:0] RST_GAIN_D_MAIN  = 24'd256000;
   localparam logic [GAIN_W-1:0] RST_GAIN_P_BREW  = 24'd256;
   localparam logic [GAIN_W-1:0] RST_GAIN_I_BREW  = 24'd0;
   localparam logic [GAIN_W-1:0] RST_GAIN_D_BREW  = 24'd0;
   localparam logic [RISE_W-1:0] RST_MAX_RISE     = 8'd2;
   localparam logic [TEMP_W-1:0] RST_EFAST_CUTOFF = 16'hFFFF;

   typedef struct packed {
      logic [HEATER_W-1:0] heater;
      logic                active;
      logic [TEMP_W-1:0]   setpoint;
      logic [TEMP_W-1:0]   temperature;
      logic [TEMP_W-1:0]   efast_value;
   } req_type;

   typedef struct packed {
      logic [HEATER_W-1:0] heater_out;
      logic [CTRL_W-1:0]   control;
      logic [POWER_W-1:0]  power;
      logic                efast_mode;
   } rsp_type;

   // per-heater state word held in the state RAM
   typedef struct packed {
      logic signed [INTEG_W-1:0] integ;
      logic signed [ERR_W-1:0]   prev_err;
      logic [TEMP_W-1:0]         prev_temp;
   } state_type;

   localparam int STATE_W = $bits(state_type);

   // override conditions, resolved in the state stage
   typedef struct packed {
      logic rise_high;
      logic dev_high;
      logic hot_rising;
      logic cool_falling;
      logic efast;
      logic brew_hot;
   } ovr_type;

   typedef struct packed {
      logic [HEATER_W-1:0]       heater;
      logic                      kill;
      logic                      flow;
      ovr_type                   ovr;
      logic signed [ERR_W-1:0]   err;
      logic signed [INTEG_W-1:0] integ;
      logic signed [DIFF_W-1:0]  diff;
   } s2_type;

   typedef struct packed {
      logic [HEATER_W-1:0]        heater;
      logic                       kill;
      logic                       flow;
      ovr_type                    ovr;
      logic signed [P_PROD_W-1:0] p_prod;
      logic signed [I_PROD_W-1:0] i_prod;
      logic signed [D_PROD_W-1:0] d_prod;
   } s3_type;

   typedef struct packed {
      logic [HEATER_W-1:0]        heater;
      logic                       kill;
      logic                       flow;
      ovr_type                    ovr;
      logic signed [PD_SUM_W-1:0] pd_sum;
      logic signed [I_PROD_W-1:0] i_prod;
   } s4_type;

   typedef struct packed {
      logic [HEATER_W-1:0]     heater;
      logic                    kill;
      logic                    flow;
      ovr_type                 ovr;
      logic signed [ACC_W-1:0] acc;
   } s5_type;

   typedef struct packed {
      logic [HEATER_W-1:0] heater;
      logic [CTRL_W-1:0]   control;
      logic [SCALED_W-1:0] scaled;
      logic                efast;
   } s6_type;

endpackage

>>> src/hpid_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hpid_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> src/heater_pid_with_overrides.sv
// PID temperature controller for several heaters with safety overrides.
// Depends on hpid_pkg and hpid_ram.
//
// Usage:
//  - req channel (req_valid/req_ready/req_data): one transaction is one control
//    tick for one heater: index, active flag, setpoint, temperature, efast.
//  - rsp channel (rsp_valid/rsp_ready/rsp_data): exactly one result per request
//    transaction, in order: heater index, control (0..10000), power word and
//    the efast mode flag.
//  - csr port: csr_wr_en with csr_index/csr_wr_data writes one register in a
//    single cycle; write only while no transactions are in flight.
//  - Throughput: one transaction per cycle unless rsp_ready holds the pipeline.
//    The per-heater state RAM is read at accept and written back when the
//    transaction leaves stage 1; the most recent write is forwarded so
//    back-to-back ticks on the same heater need no stall.
//  - Reset: registers return to their defaults and all heater state reads as
//    zero (per-entry valid bits); no clearing pass, ready right after reset.
//  - Stall: each stage holds when the next one is full, so bubbles are
//    squeezed out; req_ready drops only when all seven stages are full.
module heater_pid_with_overrides import hpid_pkg::*; #(
   parameter int NUM_HEATERS = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int ADDR_W = $clog2(NUM_HEATERS);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [GAIN_W-1:0] gain_p_main_ff, gain_i_main_ff, gain_d_main_ff;
   logic [GAIN_W-1:0] gain_p_brew_ff, gain_i_brew_ff, gain_d_brew_ff;
   logic [RISE_W-1:0] max_rise_ff;
   logic [TEMP_W-1:0] efast_cutoff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_main_ff  <= RST_GAIN_P_MAIN;
         gain_i_main_ff  <= RST_GAIN_I_MAIN;
         gain_d_main_ff  <= RST_GAIN_D_MAIN;
         gain_p_brew_ff  <= RST_GAIN_P_BREW;
         gain_i_brew_ff  <= RST_GAIN_I_BREW;
         gain_d_brew_ff  <= RST_GAIN_D_BREW;
         max_rise_ff     <= RST_MAX_RISE;
         efast_cutoff_ff <= RST_EFAST_CUTOFF;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_GAIN_P_MAIN:  gain_p_main_ff  <= csr_wr_data;
            REG_GAIN_I_MAIN:  gain_i_main_ff  <= csr_wr_data;
            REG_GAIN_D_MAIN:  gain_d_main_ff  <= csr_wr_data;
            REG_GAIN_P_BREW:  gain_p_brew_ff  <= csr_wr_data;
            REG_GAIN_I_BREW:  gain_i_brew_ff  <= csr_wr_data;
            REG_GAIN_D_BREW:  gain_d_brew_ff  <= csr_wr_data;
            REG_MAX_RISE:     max_rise_ff     <= csr_wr_data[RISE_W-1:0];
            REG_EFAST_CUTOFF: efast_cutoff_ff <= csr_wr_data[TEMP_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow control: a stage takes new data when it is empty or
   // its content moves on in the same cycle.
   // ------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s5_valid_ff, s6_valid_ff, rsp_valid_ff;
   logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, s6_rdy, out_rdy;
   logic req_fire;

   assign out_rdy  = !rsp_valid_ff || rsp_ready;
   assign s6_rdy   = !s6_valid_ff || out_rdy;
   assign s5_rdy   = !s5_valid_ff || s6_rdy;
   assign s4_rdy   = !s4_valid_ff || s5_rdy;
   assign s3_rdy   = !s3_valid_ff || s4_rdy;
   assign s2_rdy   = !s2_valid_ff || s3_rdy;
   assign s1_rdy   = !s1_valid_ff || s2_rdy;
   assign req_ready = s1_rdy;
   assign req_fire  = req_valid && s1_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_rdy)  s1_valid_ff  <= req_valid;
         if (s2_rdy)  s2_valid_ff  <= s1_valid_ff;
         if (s3_rdy)  s3_valid_ff  <= s2_valid_ff;
         if (s4_rdy)  s4_valid_ff  <= s3_valid_ff;
         if (s5_rdy)  s5_valid_ff  <= s4_valid_ff;
         if (s6_rdy)  s6_valid_ff  <= s5_valid_ff;
         if (out_rdy) rsp_valid_ff <= s6_valid_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: request register; state RAM read issued at accept
   // ------------------------------------------------------------------
   req_type                     s1_req_ff;
   logic [ADDR_W+HEATER_W-1:0]  req_addr_wide, s1_addr_wide;
   logic [ADDR_W-1:0]           req_addr, s1_addr;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff <= req_data;
      end
   end

   // heater index to RAM address, padded or trimmed to the RAM depth
   assign req_addr_wide = {{ADDR_W{1'b0}}, req_data.heater};
   assign s1_addr_wide  = {{ADDR_W{1'b0}}, s1_req_ff.heater};
   assign req_addr      = req_addr_wide[ADDR_W-1:0];
   assign s1_addr       = s1_addr_wide[ADDR_W-1:0];

   // ------------------------------------------------------------------
   // State RAM with valid bits and last-write forwarding
   // ------------------------------------------------------------------
   logic                 wr_en;
   state_type            wr_state;
   logic [STATE_W-1:0]   ram_rd_data;
   state_type            st_ram, st_cur;
   logic                 ent_valid_ff [NUM_HEATERS];
   logic                 fw_valid_ff;
   logic [ADDR_W-1:0]    fw_addr_ff;
   state_type            fw_data_ff;

   hpid_ram #(
      .WIDTH (STATE_W),
      .DEPTH (NUM_HEATERS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr),
      .wr_data (wr_state),
      .rd_en   (req_fire),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   assign st_ram = state_type'(ram_rd_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_HEATERS; i++) begin
            ent_valid_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         fw_valid_ff           <= 1'b1;
         ent_valid_ff[s1_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fw_addr_ff <= s1_addr;
         fw_data_ff <= wr_state;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1 compute: state update, errors and override conditions
   // ------------------------------------------------------------------
   logic                      s1_in_range, s1_idle, s1_flow, s1_kill;
   logic signed [ERR_W-1:0]   s1_err;
   logic signed [INTEG_W:0]   s1_isum;
   logic signed [INTEG_W-1:0] s1_integ;
   logic signed [DIFF_W-1:0]  s1_diff;
   logic signed [TEMP_W:0]    s1_rise;
   ovr_type                   s1_ovr;

   always_comb begin
      // the previous write may hit the entry this transaction read
      if (fw_valid_ff && fw_addr_ff == s1_addr) begin
         st_cur = fw_data_ff;
      end else if (s1_in_range && ent_valid_ff[s1_addr]) begin
         st_cur = st_ram;
      end else begin
         st_cur = '0;
      end
   end

   assign s1_in_range = (32'(s1_req_ff.heater) < NUM_HEATERS);
   assign s1_idle     = !s1_req_ff.active || (s1_req_ff.setpoint == '0);
   assign s1_flow     = (s1_req_ff.heater < HEATER_W'(FLOW_COUNT));
   assign s1_kill     = !s1_in_range || s1_idle;

   assign s1_err  = $signed({1'b0, s1_req_ff.setpoint}) - $signed({1'b0, s1_req_ff.temperature});
   assign s1_isum = {st_cur.integ[INTEG_W-1], st_cur.integ}
                  + {{(INTEG_W+1-ERR_W){s1_err[ERR_W-1]}}, s1_err};
   assign s1_diff = {s1_err[ERR_W-1], s1_err} - {st_cur.prev_err[ERR_W-1], st_cur.prev_err};
   assign s1_rise = $signed({1'b0, s1_req_ff.temperature}) - $signed({1'b0, st_cur.prev_temp});

   // saturate the integral to 32 bits
   always_comb begin
      if (s1_isum[INTEG_W] != s1_isum[INTEG_W-1]) begin
         s1_integ = s1_isum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                     : {1'b0, {(INTEG_W-1){1'b1}}};
      end else begin
         s1_integ = s1_isum[INTEG_W-1:0];
      end
   end

   always_comb begin
      s1_ovr.rise_high    = s1_rise > $signed({{(TEMP_W+1-RISE_W){1'b0}}, max_rise_ff});
      s1_ovr.dev_high     = s1_err > DEV_LIMIT;
      s1_ovr.hot_rising   = (s1_req_ff.temperature >= s1_req_ff.setpoint)
                          && !s1_rise[TEMP_W] && (s1_rise != '0);
      s1_ovr.cool_falling = (s1_req_ff.temperature <= s1_req_ff.setpoint) && s1_rise[TEMP_W];
      s1_ovr.efast        = s1_flow && (s1_req_ff.efast_value > efast_cutoff_ff);
      s1_ovr.brew_hot     = !s1_flow && (s1_req_ff.temperature > s1_req_ff.setpoint);
   end

   // write back when the transaction leaves stage 1; off heaters clear state
   assign wr_en = s1_valid_ff && s2_rdy && s1_in_range;

   always_comb begin
      if (s1_idle) begin
         wr_state = '0;
      end else begin
         wr_state.integ     = s1_integ;
         wr_state.prev_err  = s1_err;
         wr_state.prev_temp = s1_req_ff.temperature;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: gain products
   // ------------------------------------------------------------------
   s2_type s2_ff;
   logic [GAIN_W-1:0] kp, ki, kd;

   always_ff @(posedge clock) begin
      if (s2_rdy) begin
         s2_ff.heater <= s1_req_ff.heater;
         s2_ff.kill   <= s1_kill;
         s2_ff.flow   <= s1_flow;
         s2_ff.ovr    <= s1_ovr;
         s2_ff.err    <= s1_err;
         s2_ff.integ  <= s1_integ;
         s2_ff.diff   <= s1_diff;
      end
   end

   assign kp = s2_ff.flow ? gain_p_main_ff : gain_p_brew_ff;
   assign ki = s2_ff.flow ? gain_i_main_ff : gain_i_brew_ff;
   assign kd = s2_ff.flow ? gain_d_main_ff : gain_d_brew_ff;

   // ------------------------------------------------------------------
   // Stage 3: sum of P and D terms
   // ------------------------------------------------------------------
   s3_type s3_ff;

   always_ff @(posedge clock) begin
      if (s3_rdy) begin
         s3_ff.heater <= s2_ff.heater;
         s3_ff.kill   <= s2_ff.kill;
         s3_ff.flow   <= s2_ff.flow;
         s3_ff.ovr    <= s2_ff.ovr;
         s3_ff.p_prod <= s2_ff.err   * $signed({1'b0, kp});
         s3_ff.i_prod <= s2_ff.integ * $signed({1'b0, ki});
         s3_ff.d_prod <= s2_ff.diff  * $signed({1'b0, kd});
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: full accumulator
   // ------------------------------------------------------------------
   s4_type s4_ff;

   always_ff @(posedge clock) begin
      if (s4_rdy) begin
         s4_ff.heater <= s3_ff.heater;
         s4_ff.kill   <= s3_ff.kill;
         s4_ff.flow   <= s3_ff.flow;
         s4_ff.ovr    <= s3_ff.ovr;
         s4_ff.pd_sum <= {{(PD_SUM_W-P_PROD_W){s3_ff.p_prod[P_PROD_W-1]}}, s3_ff.p_prod}
                       + {{(PD_SUM_W-D_PROD_W){s3_ff.d_prod[D_PROD_W-1]}}, s3_ff.d_prod};
         s4_ff.i_prod <= s3_ff.i_prod;
      end
   end

   s5_type s5_ff;

   always_ff @(posedge clock) begin
      if (s5_rdy) begin
         s5_ff.heater <= s4_ff.heater;
         s5_ff.kill   <= s4_ff.kill;
         s5_ff.flow   <= s4_ff.flow;
         s5_ff.ovr    <= s4_ff.ovr;
         s5_ff.acc    <= {{(ACC_W-PD_SUM_W){s4_ff.pd_sum[PD_SUM_W-1]}}, s4_ff.pd_sum}
                       + {{(ACC_W-I_PROD_W){s4_ff.i_prod[I_PROD_W-1]}}, s4_ff.i_prod};
      end
   end

   // ------------------------------------------------------------------
   // Stage 5 compute: clamp, override chain, power pre-scale
   // ------------------------------------------------------------------
   logic [CTRL_W-1:0]   s5_ctrl;
   logic                s5_efast;
   logic [SCALED_W-1:0] s5_scaled;

   always_comb begin
      if (s5_ff.acc < ACC_MIN) begin
         s5_ctrl = '0;
      end else if (s5_ff.acc[ACC_W-2:8] > (ACC_W-9)'(CTRL_MAX)) begin
         s5_ctrl = CTRL_MAX;
      end else begin
         s5_ctrl = s5_ff.acc[CTRL_W+7:8];
      end

      // overrides, later ones win
      if (s5_ff.ovr.rise_high)  s5_ctrl = '0;
      if (s5_ff.ovr.dev_high)   s5_ctrl = CTRL_MAX;
      if (s5_ff.ovr.hot_rising) s5_ctrl = '0;
      if (s5_ff.ovr.cool_falling && (s5_ctrl < CTRL_HIGH_LIMIT)) s5_ctrl = CTRL_MAX;
      if (s5_ff.ovr.brew_hot)   s5_ctrl = '0;

      s5_efast = !s5_ff.kill && s5_ff.ovr.efast;
      if (s5_ff.kill || s5_efast) s5_ctrl = '0;

      // flow heaters: 3c/25; brewer: c/25
      if (s5_ff.flow) begin
         s5_scaled = {1'b0, s5_ctrl} + {s5_ctrl, 1'b0};
      end else begin
         s5_scaled = {1'b0, s5_ctrl};
      end
   end

   s6_type s6_ff;

   always_ff @(posedge clock) begin
      if (s6_rdy) begin
         s6_ff.heater  <= s5_ff.heater;
         s6_ff.control <= s5_ctrl;
         s6_ff.scaled  <= s5_scaled;
         s6_ff.efast   <= s5_efast;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: divide by 25 via reciprocal; output register
   // ------------------------------------------------------------------
   logic [SCALED_W+15:0] s6_prod;
   rsp_type              rsp_ff;

   assign s6_prod = s6_ff.scaled * POWER_RECIP;

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         rsp_ff.heater_out <= s6_ff.heater;
         rsp_ff.control    <= s6_ff.control;
         rsp_ff.power      <= s6_prod[POWER_SHIFT+POWER_W-1:POWER_SHIFT];
         rsp_ff.efast_mode <= s6_ff.efast;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
`ifndef ASSERT_OFF
   a_ctrl_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.control <= CTRL_MAX)
      else $error("control above full drive");

   a_efast_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.efast_mode |-> rsp_data.control == '0 && rsp_data.power == '0)
      else $error("efast result carries drive");

   a_brew_no_efast: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.heater_out >= HEATER_W'(FLOW_COUNT) |-> !rsp_data.efast_mode)
      else $error("efast mode on brewer");

   a_zero_power: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.control == '0 |-> rsp_data.power == '0)
      else $error("power without control");
`endif

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for heater_pid_with_overrides: directed ticks, random
// phases under several register settings and an integral windup run.
// Depends on hpid_pkg and the RTL of the block only.
module testbench;
   import hpid_pkg::*;

   localparam int NUM_HEATERS = 3;

   // controller constants, kept locally for the predictor
   localparam int     FULL_DRIVE   = 10000;
   localparam int     MIN_DRIVE    = 10;
   localparam int     HIGH_DRIVE   = 7500;
   localparam int     DEV_BAND     = 50;
   localparam int     BREW_DIV     = 25;
   localparam longint FLOW_NUM     = 100000;
   localparam longint FLOW_DEN     = 833333;
   localparam longint INTEG_TOP    = 64'sd2147483647;
   localparam longint INTEG_BOTTOM = -64'sd2147483648;
   localparam int     IDLE_PCT     = 29;
   localparam int     MAX_REPORTS  = 10;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   // register shadow, starts at the block's reset values
   logic [GAIN_W-1:0] cfg_p_main = RST_GAIN_P_MAIN;
   logic [GAIN_W-1:0] cfg_i_main = RST_GAIN_I_MAIN;
   logic [GAIN_W-1:0] cfg_d_main = RST_GAIN_D_MAIN;
   logic [GAIN_W-1:0] cfg_p_brew = RST_GAIN_P_BREW;
   logic [GAIN_W-1:0] cfg_i_brew = RST_GAIN_I_BREW;
   logic [GAIN_W-1:0] cfg_d_brew = RST_GAIN_D_BREW;
   logic [RISE_W-1:0] cfg_max_rise = RST_MAX_RISE;
   logic [TEMP_W-1:0] cfg_cutoff = RST_EFAST_CUTOFF;

   // per-heater loop state of the predictor, all zero after reset
   logic signed [INTEG_W-1:0] integ_sum [NUM_HEATERS] = '{default: '0};
   logic signed [ERR_W-1:0]   last_err  [NUM_HEATERS] = '{default: '0};
   logic [TEMP_W-1:0]         last_temp [NUM_HEATERS] = '{default: '0};

   req_type tick_pending [$];   // ticks waiting to be sent
   rsp_type tick_expected [$];  // predicted results, oldest first

   bit no_idle = 1'b0;
   int n_bad = 0;
   int n_checked = 0;
   int n_accepted = 0;
   int n_settings = 0;

   heater_pid_with_overrides #(
      .NUM_HEATERS(NUM_HEATERS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   // One control tick: PID with saturating integral, then the override chain
   // in fixed order, then the power word. Updates the heater's loop state.
   function automatic rsp_type predict_tick(input req_type r);
      rsp_type o;
      longint  sp, t, e, integ, d, rise, acc, kp, ki, kd;
      int      h, ctrl, pw;
      bit      flow, efast;
      o = '0;
      o.heater_out = r.heater;
      h = int'(r.heater);
      ctrl = 0;
      pw = 0;
      efast = 1'b0;
      if (h < NUM_HEATERS) begin
         if (!r.active || r.setpoint == 0) begin
            // heater off: loop state cleared, no drive
            integ_sum[h] = '0;
            last_err[h] = '0;
            last_temp[h] = '0;
         end else begin
            flow = h < FLOW_COUNT;
            kp = longint'(flow ? cfg_p_main : cfg_p_brew);
            ki = longint'(flow ? cfg_i_main : cfg_i_brew);
            kd = longint'(flow ? cfg_d_main : cfg_d_brew);
            sp = longint'(r.setpoint);
            t = longint'(r.temperature);
            e = sp - t;
            integ = longint'(integ_sum[h]) + e;
            if (integ > INTEG_TOP) integ = INTEG_TOP;
            else if (integ < INTEG_BOTTOM) integ = INTEG_BOTTOM;
            d = e - longint'(last_err[h]);
            rise = t - longint'(last_temp[h]);
            acc = e * kp + integ * ki + d * kd;
            integ_sum[h] = integ[INTEG_W-1:0];
            last_err[h] = e[ERR_W-1:0];
            last_temp[h] = r.temperature;

            // Q.8 accumulator to integer drive
            if (acc < longint'(MIN_DRIVE) * 256) ctrl = 0;
            else if (acc / 256 > FULL_DRIVE) ctrl = FULL_DRIVE;
            else ctrl = int'(acc / 256);

            if (rise > longint'(cfg_max_rise)) ctrl = 0;
            if (e > DEV_BAND) ctrl = FULL_DRIVE;
            if (t >= sp && rise > 0) ctrl = 0;
            if (t <= sp && rise < 0 && ctrl < HIGH_DRIVE) ctrl = FULL_DRIVE;
            if (flow && r.efast_value > cfg_cutoff) efast = 1'b1;
            if (!flow && t > sp) ctrl = 0;

            if (efast) begin
               ctrl = 0;
               pw = 0;
            end else if (flow) begin
               pw = int'(longint'(ctrl) * FLOW_NUM / FLOW_DEN);
            end else begin
               pw = ctrl / BREW_DIV;
            end
         end
      end
      o.control = CTRL_W'(ctrl);
      o.power = POWER_W'(pw);
      o.efast_mode = efast;
      return o;
   endfunction

   function automatic int clip16(input int v);
      if (v < 0) return 0;
      if (v > 65535) return 65535;
      return v;
   endfunction

   task automatic add_tick(input int h, input bit act, input int sp, input int t,
                           input int ef);
      req_type r;
      r.heater = HEATER_W'(h);
      r.active = act;
      r.setpoint = TEMP_W'(sp);
      r.temperature = TEMP_W'(t);
      r.efast_value = TEMP_W'(ef);
      tick_pending.push_back(r);
   endtask

   task automatic note_bad(input string what);
      n_bad++;
      if (n_bad <= MAX_REPORTS) $display("%s", what);
   endtask

   // Single-cycle register write; the shadow follows at once since the
   // block is idle whenever this runs.
   task automatic reg_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      case (idx)
         REG_GAIN_P_MAIN:  cfg_p_main = data;
         REG_GAIN_I_MAIN:  cfg_i_main = data;
         REG_GAIN_D_MAIN:  cfg_d_main = data;
         REG_GAIN_P_BREW:  cfg_p_brew = data;
         REG_GAIN_I_BREW:  cfg_i_brew = data;
         REG_GAIN_D_BREW:  cfg_d_brew = data;
         REG_MAX_RISE:     cfg_max_rise = data[RISE_W-1:0];
         REG_EFAST_CUTOFF: cfg_cutoff = data[TEMP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(input int pm, input int im, input int dm, input int pb,
                               input int ib, input int db, input int mr, input int cut);
      reg_write(REG_GAIN_P_MAIN, CSR_DATA_W'(pm));
      reg_write(REG_GAIN_I_MAIN, CSR_DATA_W'(im));
      reg_write(REG_GAIN_D_MAIN, CSR_DATA_W'(dm));
      reg_write(REG_GAIN_P_BREW, CSR_DATA_W'(pb));
      reg_write(REG_GAIN_I_BREW, CSR_DATA_W'(ib));
      reg_write(REG_GAIN_D_BREW, CSR_DATA_W'(db));
      reg_write(REG_MAX_RISE, CSR_DATA_W'(mr));
      reg_write(REG_EFAST_CUTOFF, CSR_DATA_W'(cut));
      @(posedge clock);
      csr_wr_en <= 1'b0;
      n_settings++;
   endtask

   // Waits until the sender is drained and every result is back.
   task automatic wait_idle();
      while (tick_pending.size() != 0 || req_valid || tick_expected.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // Mostly well-formed ticks: each heater walks around its own setpoint with
   // small steps, occasional jumps across the band and rises past max_rise,
   // efast values near the cutoff. The rest is raw noise on all fields.
   task automatic queue_random_phase(input int count);
      int          sp_of [4];
      int          temp_of [4];
      logic [63:0] noise;
      req_type     r;
      int          h, k, ef;
      for (k = 0; k < 4; k++) begin
         case ($urandom_range(4))
            0:       sp_of[k] = 1;
            1:       sp_of[k] = 65535;
            default: sp_of[k] = int'($urandom_range(60000, 100));
         endcase
         temp_of[k] = clip16(sp_of[k] + int'($urandom_range(20)) - 10);
      end
      for (k = 0; k < count; k++) begin
         if ($urandom_range(99) < 15) begin
            noise = {$urandom, $urandom};
            r = noise[$bits(req_type)-1:0];
         end else begin
            h = ($urandom_range(99) < 4) ? 3 : int'($urandom_range(2));
            case ($urandom_range(9))
               0: temp_of[h] = sp_of[h] + int'($urandom_range(80)) - 40;
               1: temp_of[h] = temp_of[h] + int'($urandom_range(int'(cfg_max_rise) + 3));
               default: temp_of[h] = temp_of[h] + int'($urandom_range(6)) - 3;
            endcase
            temp_of[h] = clip16(temp_of[h]);
            if ($urandom_range(3) == 0) ef = int'($urandom_range(65535));
            else ef = clip16(int'(cfg_cutoff) + int'($urandom_range(2)) - 1);
            r.heater = HEATER_W'(h);
            r.active = ($urandom_range(99) >= 4);
            r.setpoint = ($urandom_range(99) < 3) ? '0 : TEMP_W'(sp_of[h]);
            r.temperature = TEMP_W'(temp_of[h]);
            r.efast_value = TEMP_W'(ef);
         end
         tick_pending.push_back(r);
      end
   endtask

   // Request driver: predicts each accepted transaction, then offers the next
   // pending tick unless it decides to idle this cycle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            tick_expected.push_back(predict_tick(req_data));
            n_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (tick_pending.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
               req_valid <= 1'b1;
               req_data <= tick_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: random backpressure, in-order compare against predictions.
   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (tick_expected.size() == 0) begin
               note_bad($sformatf("unexpected result at %0t: heater %0d control %0d",
                                  $time, rsp_data.heater_out, rsp_data.control));
            end else begin
               want = tick_expected.pop_front();
               n_checked++;
               if (rsp_data.heater_out !== want.heater_out ||
                   rsp_data.control !== want.control ||
                   rsp_data.power !== want.power ||
                   rsp_data.efast_mode !== want.efast_mode) begin
                  note_bad($sformatf(
                     "result %0d at %0t: expected h%0d c%0d p%0d ef%0b, got h%0d c%0d p%0d ef%0b",
                     n_checked, $time, want.heater_out, want.control, want.power,
                     want.efast_mode, rsp_data.heater_out, rsp_data.control,
                     rsp_data.power, rsp_data.efast_mode));
               end
            end
         end
         rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Watchdog: the slowest legal run is well under a tenth of this.
   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      int k;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, default registers: rise limit, falling below setpoint,
      // at/above setpoint rising, large deviation both ways, heater off
      // by flag and by zero setpoint, brewer above setpoint, unused index.
      add_tick(0, 1, 1000, 998, 0);
      add_tick(0, 1, 1000, 999, 5);
      add_tick(0, 1, 1000, 997, 0);
      add_tick(0, 1, 1000, 1000, 0);
      add_tick(0, 1, 1000, 1001, 0);
      add_tick(0, 1, 1000, 1001, 0);
      add_tick(0, 0, 1000, 990, 0);
      add_tick(0, 1, 0, 990, 0);
      add_tick(1, 1, 65535, 0, 0);
      add_tick(1, 1, 65535, 2, 0);
      add_tick(1, 1, 1, 65535, 65535);
      add_tick(1, 1, 65535, 65535, 65535);
      add_tick(2, 1, 500, 499, 0);
      add_tick(2, 1, 500, 500, 0);
      add_tick(2, 1, 500, 501, 0);
      add_tick(2, 1, 500, 499, 0);
      add_tick(2, 1, 500, 460, 0);
      add_tick(2, 0, 500, 500, 0);
      add_tick(3, 1, 1000, 990, 0);
      add_tick(3, 0, 0, 0, 0);
      add_tick(3, 1, 65535, 65535, 65535);
      wait_idle();

      // efast: just above and at the cutoff on flow heaters, ignored on brewer
      apply_config(25600, 1152, 256000, 256, 0, 0, 2, 100);
      add_tick(0, 1, 1000, 1000, 101);
      add_tick(0, 1, 1000, 1000, 100);
      add_tick(1, 1, 2000, 1990, 65535);
      add_tick(2, 1, 500, 500, 65535);
      wait_idle();

      // random phases, one register setting each, extremes included
      apply_config(25600, 1152, 256000, 256, 0, 0, 2, 65535);
      queue_random_phase(130);
      wait_idle();
      apply_config($urandom_range(1 << 18), $urandom_range(1 << 12), $urandom_range(1 << 18),
                   $urandom_range(1 << 18), $urandom_range(1 << 12), $urandom_range(1 << 18),
                   $urandom_range(8), $urandom_range(65535));
      queue_random_phase(130);
      wait_idle();
      apply_config(0, 0, 0, 0, 0, 0, 0, 0);
      queue_random_phase(130);
      wait_idle();
      apply_config(16777215, 16777215, 16777215, 16777215, 16777215, 16777215, 255, 65535);
      queue_random_phase(130);
      wait_idle();
      apply_config($urandom_range(16777215), $urandom_range(16777215),
                   $urandom_range(16777215), $urandom_range(16777215),
                   $urandom_range(16777215), $urandom_range(16777215),
                   $urandom_range(255), $urandom_range(65535));
      queue_random_phase(130);
      wait_idle();
      apply_config($urandom_range(4096), $urandom_range(64), $urandom_range(4096),
                   $urandom_range(4096), $urandom_range(64), $urandom_range(4096),
                   $urandom_range(4), $urandom_range(65535));
      queue_random_phase(130);
      wait_idle();

      // Integral windup on a flow heater, back to back with no idling:
      // pure I gain so control tracks the integral; push it far up with the
      // largest positive error, then pull it down with the largest negative.
      apply_config(0, 1, 0, 256, 0, 0, 255, 65535);
      no_idle = 1'b1;
      for (k = 0; k < 50; k++) add_tick(0, 1, 65535, 0, 0);
      for (k = 0; k < 50; k++) add_tick(0, 1, 1, 65535, 0);
      wait_idle();
      no_idle = 1'b0;

      $display("Covered %0d control ticks under %0d register settings, incl. windup.",
               n_accepted, n_settings);
      $display("%0d results checked, %0d bad.", n_checked, n_bad);
      if (n_bad == 0 && tick_expected.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> files.f
src/hpid_pkg.sv
src/hpid_ram.sv
src/heater_pid_with_overrides.sv
sim/testbench.sv
